@@ rtl/rtli_pkg.sv @@
// Shared types and constants for the ranked top list block.
// Holds the transfer payload structs, list geometry and the controller command set.
// No dependencies.
package rtli_pkg;

  // list geometry
  localparam int ENTRIES   = 10;
  localparam int TABLES    = 3;
  localparam int NAME_BITS = 64;
  localparam int SLOTS     = TABLES * ENTRIES;

  // derived widths
  localparam int ADDR_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int RANK_W  = $clog2(ENTRIES + 1);
  localparam int SCORE_W = 32;
  localparam int FLAT_W  = 5;

  // operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_READ   = 1'b1;

  typedef struct packed {
    logic                      operation;
    logic [1:0]                table_select;
    logic signed [SCORE_W-1:0] new_score;
    logic [63:0]               name_tag;
    logic [3:0]                entry_index;
  } in_t;

  typedef struct packed {
    logic                      placed;
    logic [FLAT_W-1:0]         flat_position;
    logic signed [SCORE_W-1:0] entry_score;
    logic [63:0]               entry_name;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic load;        // latch the accepted item
    logic rd_entry;    // read one entry for a read operation
    logic scan_first;  // read the first rank of an insert scan
    logic step;        // compare, write and advance one rank
    logic finish;      // load the result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_insert;
    logic tbl_ok;
    logic idx_ok;
    logic last;
    logic out_free;
  } stat_t;

endpackage

@@ rtl/ranked_top_list_insert.sv @@
// Ranked top list block, top level.
// Instantiates rtli_ctrl and rtli_datapath; uses rtli_pkg.
//
// Keeps three ranked lists of ten entries (score, name tag) in descending
// score order, in one slot memory with a valid bit per slot.
// Input channel: in_valid_i / in_stall_o with in_data_i; a transfer takes
// place on a clock edge with valid high and stall low. Operation insert
// places the entry behind equal scores and reports its flat position;
// operation read returns one entry. Each item yields exactly one result.
// Output channel: out_valid_o / out_stall_i with out_data_o.
// An insert walks all ten ranks of its list, reading one rank and writing the
// rank above it each cycle; a read reads its one entry, and a skipped item
// goes straight from the start state to the finish state, where every item
// loads its result. The result can transfer out in the cycle after it is
// loaded, and the next item is taken in the cycle after the result is loaded.
// Reset clears all valid bits at once, so every list reads as zero; no
// clearing pass is needed. A waiting result does not block the next
// transfer in; when the receiver stalls, the finished result of that next
// item waits in the controller until the output register frees up.
module ranked_top_list_insert (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  rtli_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output rtli_pkg::out_t out_data_o
);
  import rtli_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  rtli_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // memory, scan and result registers
  rtli_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

@@ rtl/rtli_datapath.sv @@
// Datapath of the ranked top list block: entry memory with valid bits, scan
// registers and the result register. Driven by rtli_ctrl; uses rtli_pkg.
module rtli_datapath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rtli_pkg::in_t  in_data_i,
  input  rtli_pkg::cmd_t cmd_i,
  output rtli_pkg::stat_t stat_o,
  input  logic           out_stall_i,
  output logic           out_valid_o,
  output rtli_pkg::out_t out_data_o
);
  import rtli_pkg::*;

  // entry memory, one score and one name per slot
  logic signed [SCORE_W-1:0] score_mem [SLOTS];
  logic [NAME_BITS-1:0]      name_mem  [SLOTS];
  logic [SLOTS-1:0]          valid_q;

  in_t                       item_q;
  logic                      tbl_ok_q;
  logic [ADDR_W-1:0]         base_q;
  logic [RANK_W-1:0]         rank_q, rank_d;
  logic                      placed_q;
  logic [ADDR_W-1:0]         place_addr_q;
  logic signed [SCORE_W-1:0] held_score_q;
  logic [NAME_BITS-1:0]      held_name_q;

  logic signed [SCORE_W-1:0] rd_score_q;
  logic [NAME_BITS-1:0]      rd_name_q;
  logic                      rd_valid_q;
  logic [ADDR_W-1:0]         rd_addr_q;

  out_t                      out_q, out_d;
  logic                      out_valid_q;

  logic                      in_tbl_ok;
  logic [1:0]                eff_tbl;
  logic [ADDR_W-1:0]         base_d;
  logic                      idx_ok;
  logic                      last;
  logic                      rd_en;
  logic [ADDR_W-1:0]         rd_addr;
  logic signed [SCORE_W-1:0] cur_score;
  logic [NAME_BITS-1:0]      cur_name;
  logic                      beats;
  logic                      wr_en;
  logic signed [SCORE_W-1:0] wr_score;
  logic [NAME_BITS-1:0]      wr_name;

  // table base for the incoming item, unknown tables map to list 0
  assign in_tbl_ok = 32'(in_data_i.table_select) < TABLES;
  assign eff_tbl   = in_tbl_ok ? in_data_i.table_select : 2'd0;
  assign base_d    = ADDR_W'(32'(eff_tbl) * ENTRIES);

  assign idx_ok = 32'(item_q.entry_index) < ENTRIES;
  assign last   = rank_q == RANK_W'(ENTRIES);

  // current entry of the scan, never written slots read as zero
  assign cur_score = rd_valid_q ? rd_score_q : '0;
  assign cur_name  = rd_valid_q ? rd_name_q : '0;
  assign beats     = item_q.new_score > cur_score;

  // once placed, each later rank takes the entry held from the rank above
  assign wr_en    = cmd_i.step && (placed_q || beats);
  assign wr_score = placed_q ? held_score_q : item_q.new_score;
  assign wr_name  = placed_q ? held_name_q : item_q.name_tag[NAME_BITS-1:0];

  // read port address
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = base_q;
    rank_d  = rank_q;
    if (cmd_i.rd_entry) begin
      rd_en   = 1'b1;
      rd_addr = base_q + ADDR_W'(item_q.entry_index);
    end else if (cmd_i.scan_first) begin
      rd_en   = 1'b1;
      rd_addr = base_q;
      rank_d  = RANK_W'(1);
    end else if (cmd_i.step && !last) begin
      rd_en   = 1'b1;
      rd_addr = base_q + ADDR_W'(rank_q);
      rank_d  = rank_q + RANK_W'(1);
    end
  end

  // memory write and registered read, distinct addresses in one cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      score_mem[rd_addr_q] <= wr_score;
      name_mem[rd_addr_q]  <= wr_name;
    end
    if (rd_en) begin
      rd_score_q <= score_mem[rd_addr];
      rd_name_q  <= name_mem[rd_addr];
      rd_valid_q <= valid_q[rd_addr];
      rd_addr_q  <= rd_addr;
    end
  end

  // valid bits, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en) begin
      valid_q[rd_addr_q] <= 1'b1;
    end
  end

  // item and scan registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q   <= in_data_i;
      tbl_ok_q <= in_tbl_ok;
      base_q   <= base_d;
    end
    rank_q <= rank_d;
    if (wr_en) begin
      held_score_q <= cur_score;
      held_name_q  <= cur_name;
      if (!placed_q) begin
        place_addr_q <= rd_addr_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      placed_q <= 1'b0;
    end else if (cmd_i.load) begin
      placed_q <= 1'b0;
    end else if (wr_en) begin
      placed_q <= 1'b1;
    end
  end

  // result build
  always_comb begin
    out_d = '0;
    if (item_q.operation == OP_INSERT) begin
      out_d.placed        = placed_q;
      out_d.flat_position = placed_q ? FLAT_W'(32'(place_addr_q)) : '0;
    end else if (idx_ok && rd_valid_q) begin
      out_d.entry_score = rd_score_q;
      out_d.entry_name  = 64'(rd_name_q);
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign stat_o.is_insert = item_q.operation == OP_INSERT;
  assign stat_o.tbl_ok    = tbl_ok_q;
  assign stat_o.idx_ok    = idx_ok;
  assign stat_o.last      = last;
  assign stat_o.out_free  = !out_valid_q || !out_stall_i;

  // a result is never loaded over one that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> (!out_valid_q || !out_stall_i))
    else $error("result register overwritten while stalled");

  // memory writes only happen during an insert scan of a known table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (item_q.operation == OP_INSERT && tbl_ok_q))
    else $error("memory write outside an insert scan");

  // a read of the same slot as the write would see stale data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && rd_en) |-> (rd_addr != rd_addr_q))
    else $error("read and write collide on one slot");

  // a placed insert lands inside its own list
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && placed_q) |-> (place_addr_q >= base_q
      && 32'(place_addr_q) < 32'(base_q) + ENTRIES))
    else $error("placed entry outside its list");

endmodule

@@ rtl/rtli_ctrl.sv @@
// Controller of the ranked top list block: sequences accept, scan or read,
// and result loading. Commands rtli_datapath; uses rtli_pkg.
module rtli_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  rtli_pkg::stat_t stat_i,
  output rtli_pkg::cmd_t  cmd_o
);
  import rtli_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_START  = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_RDATA  = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0] state_q, state_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_START;
        end
      end
      ST_START: begin
        if (stat_i.is_insert) begin
          if (stat_i.tbl_ok) begin
            cmd_o.scan_first = 1'b1;
            state_d          = ST_SCAN;
          end else begin
            state_d = ST_FINISH;
          end
        end else if (stat_i.idx_ok) begin
          cmd_o.rd_entry = 1'b1;
          state_d        = ST_RDATA;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_SCAN: begin
        cmd_o.step = 1'b1;
        if (stat_i.last) begin
          state_d = ST_FINISH;
        end
      end
      ST_RDATA: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = state_q != ST_IDLE;

  // a scan keeps stepping until its last rank
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && !stat_i.last) |=> state_q == ST_SCAN)
    else $error("insert scan ended early");

  // an accepted item moves on to the start state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == ST_START)
    else $error("accepted item not started");

  // the state register only holds known codes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q <= ST_FINISH)
    else $error("illegal controller state");

endmodule
